/* hdl/tgrt_pkg.sv */
// shared constants, types and helpers of the tile grid ray traversal unit
package tgrt_pkg;

  localparam int MAX_MAP_COLS = 128;
  localparam int MAX_MAP_ROWS = 128;
  localparam int NUM_LAYERS   = 4;
  localparam int STEP_LIMIT   = 512;

  localparam int CELLS   = MAX_MAP_COLS * MAX_MAP_ROWS;
  localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CIDX_W  = (MAX_MAP_COLS > 1) ? $clog2(MAX_MAP_COLS) : 1;
  localparam int RIDX_W  = (MAX_MAP_ROWS > 1) ? $clog2(MAX_MAP_ROWS) : 1;
  localparam int STEP_W  = $clog2(STEP_LIMIT + 1);

  localparam int PT_W    = 20;
  localparam int TILE_W  = 13;
  localparam int ID_W    = 16;
  localparam int LAYER_W = 2;
  localparam int OC_W    = 3;
  localparam int CW      = 17;   // column / row counters
  localparam int TPX_W   = 12;   // tile size in q4 units
  localparam int MACC_W  = 42;   // walk accumulators
  localparam int DIFF_W  = 22;
  localparam int SUM_W   = 45;

  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;

  localparam int DIV_NUM_W  = 43;
  localparam int DIV_DEN_W  = 20;
  localparam int DIV_CNT_W  = 6;
  localparam int TILE_NUM_W = 15;

  localparam logic signed [SUM_W-1:0] PT_MAX = SUM_W'(524287);
  localparam logic signed [SUM_W-1:0] PT_MIN = -SUM_W'(524288);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILE_W   = 3'd0,
    CFG_TILE_H   = 3'd1,
    CFG_MAP_W    = 3'd2,
    CFG_MAP_H    = 3'd3,
    CFG_COLLIDE  = 3'd4
  } cfg_idx_e;

  typedef enum logic [OC_W-1:0] {
    OC_REACHED     = 3'd0,
    OC_HIT         = 3'd1,
    OC_START_SOLID = 3'd2,
    OC_SAME_TILE   = 3'd3,
    OC_STEP_LIMIT  = 3'd4
  } outcome_e;

  typedef enum logic [2:0] {
    DIV_SX, DIV_SY, DIV_EX, DIV_EY, DIV_HIT
  } div_src_e;

  typedef enum logic [2:0] {
    MUL_MX, MUL_MY, MUL_IX, MUL_IY, MUL_HIT
  } mul_sel_e;

  typedef struct packed {
    logic     clear;
    logic     load;
    logic     write;
    logic     div_go;
    div_src_e div_src;
    logic     mul_go;
    mul_sel_e mul_sel;
    logic     step;
    logic     hit_prep;
    logic     emit;
    outcome_e outcome;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic div_busy;
    logic same_tile;
    logic solid;
    logic step_limit;
    logic out_free;
  } sts_t;

  function automatic logic signed [PT_W-1:0] sat_pt(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] r;
    r = (v > PT_MAX) ? PT_MAX : ((v < PT_MIN) ? PT_MIN : v);
    return r[PT_W-1:0];
  endfunction

endpackage

/* hdl/tgrt_ram.sv */
// generic single write port, single read port ram with registered read
module tgrt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hdl/tgrt_div.sv */
// iterative restoring divider, one quotient bit per cycle
module tgrt_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [tgrt_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [tgrt_pkg::DIV_DEN_W-1:0] den_i,
  input  logic [tgrt_pkg::DIV_CNT_W-1:0] iters_i,
  output logic                           busy_o,
  output logic                           done_o,
  output logic [tgrt_pkg::DIV_NUM_W-1:0] quo_o,
  output logic [tgrt_pkg::DIV_DEN_W-1:0] rem_o
);
  import tgrt_pkg::*;

  logic [DIV_NUM_W-1:0] n_q;
  logic [DIV_DEN_W-1:0] rem_q, den_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic [DIV_DEN_W:0]   trial, diff;
  logic                 ge;

  assign trial = {rem_q, n_q[DIV_NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= iters_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      n_q   <= {n_q[DIV_NUM_W-2:0], ge};
      rem_q <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = n_q;
  assign rem_o  = rem_q;

endmodule

/* hdl/tgrt_datapath.sv */
// datapath: config registers, tile store, walk accumulators, divider and output register
module tgrt_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tgrt_pkg::cmd_t                  cmd_i,
  output tgrt_pkg::sts_t                  sts_o,
  input  logic [tgrt_pkg::IN_TDATA_W-1:0] s_tdata_i,
  input  logic                            cfg_valid_i,
  input  logic [tgrt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tgrt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  output logic [tgrt_pkg::OUT_TDATA_W-1:0] m_tdata_o,
  output logic [tgrt_pkg::OC_W-1:0]       m_tuser_o
);
  import tgrt_pkg::*;

  // configuration
  logic [7:0] tile_w_q, tile_h_q, map_w_q, map_h_q;
  logic [3:0] mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_w_q <= 8'd32;
      tile_h_q <= 8'd32;
      map_w_q  <= 8'd128;
      map_h_q  <= 8'd128;
      mask_q   <= 4'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TILE_W:  tile_w_q <= cfg_data_i;
        CFG_TILE_H:  tile_h_q <= cfg_data_i;
        CFG_MAP_W:   map_w_q  <= cfg_data_i;
        CFG_MAP_H:   map_h_q  <= cfg_data_i;
        CFG_COLLIDE: mask_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  logic [7:0]       w_eff, h_eff;
  logic [TPX_W-1:0] tw, th;
  logic [CW-1:0]    cols, rows;

  assign w_eff = (tile_w_q == 8'd0) ? 8'd1 : tile_w_q;
  assign h_eff = (tile_h_q == 8'd0) ? 8'd1 : tile_h_q;
  assign tw    = {w_eff, 4'b0};
  assign th    = {h_eff, 4'b0};
  assign cols  = (CW'(map_w_q) > CW'(MAX_MAP_COLS)) ? CW'(MAX_MAP_COLS) : CW'(map_w_q);
  assign rows  = (CW'(map_h_q) > CW'(MAX_MAP_ROWS)) ? CW'(MAX_MAP_ROWS) : CW'(map_h_q);

  // item registers
  logic [LAYER_W-1:0]      layer_q;
  logic signed [TILE_W-1:0] tx_q, ty_q;
  logic [ID_W-1:0]         val_q;
  logic signed [PT_W-1:0]  sx_q, sy_q, ex_q, ey_q;
  logic [PT_W-1:0]         adx_q, ady_q;
  logic                    xneg_q, yneg_q, dxneg_q, dyneg_q;

  logic signed [PT_W:0] dx_in, dy_in;
  logic signed [PT_W-1:0] sx_in, sy_in, ex_in, ey_in;

  assign sx_in = s_tdata_i[63:44];
  assign sy_in = s_tdata_i[83:64];
  assign ex_in = s_tdata_i[103:84];
  assign ey_in = s_tdata_i[123:104];
  assign dx_in = {ex_in[PT_W-1], ex_in} - {sx_in[PT_W-1], sx_in};
  assign dy_in = {ey_in[PT_W-1], ey_in} - {sy_in[PT_W-1], sy_in};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      layer_q <= s_tdata_i[1:0];
      tx_q    <= s_tdata_i[14:2];
      ty_q    <= s_tdata_i[27:15];
      val_q   <= s_tdata_i[43:28];
      sx_q    <= sx_in;
      sy_q    <= sy_in;
      ex_q    <= ex_in;
      ey_q    <= ey_in;
      dxneg_q <= dx_in[PT_W];
      dyneg_q <= dy_in[PT_W];
      xneg_q  <= !(ex_in > sx_in);
      yneg_q  <= !(ey_in > sy_in);
      adx_q   <= dx_in[PT_W] ? PT_W'(-dx_in) : dx_in[PT_W-1:0];
      ady_q   <= dy_in[PT_W] ? PT_W'(-dy_in) : dy_in[PT_W-1:0];
    end
  end

  // shared divider
  logic                 div_busy, div_done;
  logic [DIV_NUM_W-1:0] div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den, div_rem;
  logic [DIV_CNT_W-1:0] div_iters;
  div_src_e             div_src_q;

  logic signed [PT_W-1:0] go_x, st_x;
  logic signed [15:0]     go_a;
  logic [TILE_NUM_W-1:0]  go_n;

  logic [PT_W-1:0]     ad_q, oth_abs_q;
  logic [DIFF_W-1:0]   diff_abs_q;
  logic                neg_q, lastx_q;
  logic signed [DIFF_W:0] b_q;
  logic [MACC_W-1:0]   prod_q;
  logic [DIV_NUM_W-1:0] q_q;

  always_comb begin
    case (cmd_i.div_src)
      DIV_SX:  go_x = sx_q;
      DIV_SY:  go_x = sy_q;
      DIV_EX:  go_x = ex_q;
      default: go_x = ey_q;
    endcase
    go_a = go_x[PT_W-1:4];
    go_n = go_a[15] ? ~go_a[TILE_NUM_W-1:0] : go_a[TILE_NUM_W-1:0];
    if (cmd_i.div_src == DIV_HIT) begin
      div_num   = DIV_NUM_W'(prod_q) + DIV_NUM_W'(ad_q >> 1);
      div_den   = ad_q;
      div_iters = DIV_CNT_W'(DIV_NUM_W);
    end else begin
      div_num   = {go_n, (DIV_NUM_W - TILE_NUM_W)'(0)};
      div_den   = (cmd_i.div_src == DIV_SX || cmd_i.div_src == DIV_EX) ?
                  DIV_DEN_W'(w_eff) : DIV_DEN_W'(h_eff);
      div_iters = DIV_CNT_W'(TILE_NUM_W);
    end
  end

  tgrt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_go),
    .num_i   (div_num),
    .den_i   (div_den),
    .iters_i (div_iters),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .rem_o   (div_rem)
  );

  // floored tile coordinate and offset inside the tile from the divider result
  logic [7:0]        dn_w, dn_r;
  logic [CW-1:0]     dn_c;
  logic [TPX_W-1:0]  dn_off;
  logic              dn_neg;

  always_comb begin
    case (div_src_q)
      DIV_SX:  st_x = sx_q;
      DIV_SY:  st_x = sy_q;
      DIV_EX:  st_x = ex_q;
      default: st_x = ey_q;
    endcase
    dn_neg = st_x[PT_W-1];
    dn_w   = (div_src_q == DIV_SX || div_src_q == DIV_EX) ? w_eff : h_eff;
    dn_c   = dn_neg ? ~CW'(div_quo[TILE_NUM_W-1:0]) : CW'(div_quo[TILE_NUM_W-1:0]);
    dn_r   = dn_neg ? (dn_w - 8'd1 - div_rem[7:0]) : div_rem[7:0];
    dn_off = {dn_r, st_x[3:0]};
  end

  // walk state
  logic signed [CW-1:0]   col_q, row_q, ecol_q, erow_q;
  logic [TPX_W-1:0]       rx_q, ry_q;
  logic signed [DIFF_W:0] basex_q, basey_q;
  logic [MACC_W-1:0]      mx_q, my_q, incx_q, incy_q;
  logic [STEP_W-1:0]      steps_q;

  logic [PT_W-1:0]   mul_a;
  logic [DIFF_W-1:0] mul_b;
  logic [MACC_W-1:0] mul_p;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_MX: begin
        mul_a = ady_q;
        mul_b = DIFF_W'(xneg_q ? rx_q : tw - rx_q);
      end
      MUL_MY: begin
        mul_a = adx_q;
        mul_b = DIFF_W'(yneg_q ? ry_q : th - ry_q);
      end
      MUL_IX: begin
        mul_a = ady_q;
        mul_b = DIFF_W'(tw);
      end
      MUL_IY: begin
        mul_a = adx_q;
        mul_b = DIFF_W'(th);
      end
      default: begin
        mul_a = oth_abs_q;
        mul_b = diff_abs_q;
      end
    endcase
    mul_p = MACC_W'(mul_a) * MACC_W'(mul_b);
  end

  logic take_x;
  assign take_x = (ady_q == '0) || (mx_q < my_q);

  // hit preparation values
  logic signed [DIFF_W:0] hp_b, hp_diff;

  always_comb begin
    if (lastx_q) begin
      hp_b    = xneg_q ? basex_q + (DIFF_W+1)'(tw) : basex_q;
      hp_diff = hp_b - (DIFF_W+1)'(sx_q);
    end else begin
      hp_b    = yneg_q ? basey_q + (DIFF_W+1)'(th) : basey_q;
      hp_diff = hp_b - (DIFF_W+1)'(sy_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_src_q <= DIV_SX;
      steps_q   <= '0;
    end else begin
      if (cmd_i.div_go) begin
        div_src_q <= cmd_i.div_src;
      end
      if (cmd_i.load) begin
        steps_q <= '0;
      end else if (cmd_i.step) begin
        steps_q <= steps_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      case (div_src_q)
        DIV_SX: begin
          col_q   <= dn_c;
          rx_q    <= dn_off;
          basex_q <= (DIFF_W+1)'(sx_q) - (DIFF_W+1)'(dn_off);
        end
        DIV_SY: begin
          row_q   <= dn_c;
          ry_q    <= dn_off;
          basey_q <= (DIFF_W+1)'(sy_q) - (DIFF_W+1)'(dn_off);
        end
        DIV_EX:  ecol_q <= dn_c;
        DIV_EY:  erow_q <= dn_c;
        default: q_q    <= (ad_q == '0) ? '0 : div_quo;
      endcase
    end
    if (cmd_i.mul_go) begin
      case (cmd_i.mul_sel)
        MUL_MX:  mx_q   <= mul_p;
        MUL_MY:  my_q   <= mul_p;
        MUL_IX:  incx_q <= mul_p;
        MUL_IY:  incy_q <= mul_p;
        default: prod_q <= mul_p;
      endcase
    end
    if (cmd_i.step) begin
      lastx_q <= take_x;
      if (take_x) begin
        mx_q    <= mx_q + incx_q;
        col_q   <= xneg_q ? col_q - CW'(1) : col_q + CW'(1);
        basex_q <= xneg_q ? basex_q - (DIFF_W+1)'(tw) : basex_q + (DIFF_W+1)'(tw);
      end else begin
        my_q    <= my_q + incy_q;
        row_q   <= yneg_q ? row_q - CW'(1) : row_q + CW'(1);
        basey_q <= yneg_q ? basey_q - (DIFF_W+1)'(th) : basey_q + (DIFF_W+1)'(th);
      end
    end
    if (cmd_i.hit_prep) begin
      b_q        <= hp_b;
      diff_abs_q <= hp_diff[DIFF_W] ? DIFF_W'(-hp_diff) : hp_diff[DIFF_W-1:0];
      ad_q       <= lastx_q ? adx_q : ady_q;
      oth_abs_q  <= lastx_q ? ady_q : adx_q;
      neg_q      <= hp_diff[DIFF_W] ^ (lastx_q ? (dyneg_q ^ dxneg_q) : (dxneg_q ^ dyneg_q));
    end
  end

  // tile store, one ram per layer, cleared by a sweep after reset
  logic [ADDR_W-1:0] clr_q, waddr, raddr;
  logic              wr_ok;
  logic [ID_W-1:0]   rd_data [NUM_LAYERS];
  logic [NUM_LAYERS-1:0] hit_layer;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  assign wr_ok = !tx_q[TILE_W-1] && (CW'(unsigned'(tx_q)) < cols) &&
                 !ty_q[TILE_W-1] && (CW'(unsigned'(ty_q)) < rows);
  assign waddr = cmd_i.clear ? clr_q :
                 ADDR_W'(ADDR_W'(ty_q[RIDX_W-1:0]) * ADDR_W'(MAX_MAP_COLS)) +
                 ADDR_W'(tx_q[CIDX_W-1:0]);
  assign raddr = ADDR_W'(ADDR_W'(row_q[RIDX_W-1:0]) * ADDR_W'(MAX_MAP_COLS)) +
                 ADDR_W'(col_q[CIDX_W-1:0]);

  for (genvar l = 0; l < NUM_LAYERS; l++) begin : g_layer
    logic we;
    assign we = cmd_i.clear || (cmd_i.write && wr_ok && (int'(layer_q) == l));
    tgrt_ram #(
      .WIDTH (ID_W),
      .DEPTH (CELLS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (cmd_i.clear ? '0 : val_q),
      .raddr_i (raddr),
      .rdata_o (rd_data[l])
    );
    if (l < 4) begin : g_coll
      assign hit_layer[l] = mask_q[l] && (rd_data[l] != '0);
    end else begin : g_nocoll
      assign hit_layer[l] = 1'b0;
    end
  end

  logic oob;
  assign oob = col_q[CW-1] || (col_q >= signed'(cols)) ||
               row_q[CW-1] || (row_q >= signed'(rows));

  // output register
  logic                   out_v_q;
  logic [OC_W-1:0]        oc_q;
  logic signed [PT_W-1:0] px_q, py_q;
  logic [TILE_W-1:0]      hc_q, hr_q;

  logic signed [SUM_W-1:0] qs, oth_sum, b_ext;
  logic signed [PT_W-1:0]  px_d, py_d;

  always_comb begin
    qs      = neg_q ? -SUM_W'(q_q) : SUM_W'(q_q);
    oth_sum = (lastx_q ? SUM_W'(sy_q) : SUM_W'(sx_q)) + qs;
    b_ext   = SUM_W'(b_q);
    case (cmd_i.outcome)
      OC_HIT: begin
        px_d = lastx_q ? sat_pt(b_ext) : sat_pt(oth_sum);
        py_d = lastx_q ? sat_pt(oth_sum) : sat_pt(b_ext);
      end
      OC_START_SOLID: begin
        px_d = sx_q;
        py_d = sy_q;
      end
      default: begin
        px_d = ex_q;
        py_d = ey_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_v_q <= 1'b1;
    end else if (m_tready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      oc_q <= cmd_i.outcome;
      px_q <= px_d;
      py_q <= py_d;
      hc_q <= (cmd_i.outcome == OC_HIT) ? col_q[TILE_W-1:0] : '0;
      hr_q <= (cmd_i.outcome == OC_HIT) ? row_q[TILE_W-1:0] : '0;
    end
  end

  assign m_tvalid_o = out_v_q;
  assign m_tuser_o  = oc_q;
  assign m_tdata_o  = {6'b0, hr_q, hc_q, py_q, px_q};

  assign sts_o.clear_done = (clr_q == ADDR_W'(CELLS - 1));
  assign sts_o.div_busy   = div_busy;
  assign sts_o.same_tile  = (col_q == ecol_q) && (row_q == erow_q);
  assign sts_o.solid      = oob || (|hit_layer);
  assign sts_o.step_limit = (steps_q == STEP_W'(STEP_LIMIT));
  assign sts_o.out_free   = !out_v_q || m_tready_i;

endmodule

/* hdl/tgrt_ctrl.sv */
// controller state machine sequencing writes, tile divisions, the walk and the hit point
module tgrt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_tvalid_i,
  input  logic           s_mode_i,
  output logic           s_tready_o,
  output tgrt_pkg::cmd_t cmd_o,
  input  tgrt_pkg::sts_t sts_i
);
  import tgrt_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_WRITE, ST_DIV, ST_DWAIT, ST_CHECK, ST_LOOK, ST_TEST,
    ST_MX, ST_MY, ST_IX, ST_IY, ST_STEP, ST_HPREP, ST_HMUL, ST_HDIV, ST_HWAIT,
    ST_EMIT
  } state_e;

  state_e   state_q;
  div_src_e src_q;
  logic     first_q;
  outcome_e oc_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.div_src = src_q;
    cmd_o.mul_sel = MUL_MX;
    cmd_o.outcome = oc_q;
    s_tready_o    = (state_q == ST_IDLE);
    cmd_o.load    = s_tready_o && s_tvalid_i;
    case (state_q)
      ST_CLEAR: cmd_o.clear  = 1'b1;
      ST_WRITE: cmd_o.write  = 1'b1;
      ST_DIV:   cmd_o.div_go = 1'b1;
      ST_MX: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = MUL_MX;
      end
      ST_MY: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = MUL_MY;
      end
      ST_IX: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = MUL_IX;
      end
      ST_IY: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = MUL_IY;
      end
      ST_STEP:  cmd_o.step = !sts_i.same_tile && !sts_i.step_limit;
      ST_HPREP: cmd_o.hit_prep = 1'b1;
      ST_HMUL: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = MUL_HIT;
      end
      ST_HDIV: begin
        cmd_o.div_go  = 1'b1;
        cmd_o.div_src = DIV_HIT;
      end
      ST_EMIT:  cmd_o.emit = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      src_q   <= DIV_SX;
      first_q <= 1'b0;
      oc_q    <= OC_REACHED;
    end else begin
      case (state_q)
        ST_CLEAR: if (sts_i.clear_done) state_q <= ST_IDLE;
        ST_IDLE: begin
          if (s_tvalid_i) begin
            src_q   <= DIV_SX;
            state_q <= s_mode_i ? ST_DIV : ST_WRITE;
          end
        end
        ST_WRITE: state_q <= ST_IDLE;
        ST_DIV:   state_q <= ST_DWAIT;
        ST_DWAIT: begin
          if (!sts_i.div_busy) begin
            case (src_q)
              DIV_SX:  src_q <= DIV_SY;
              DIV_SY:  src_q <= DIV_EX;
              DIV_EX:  src_q <= DIV_EY;
              default: src_q <= DIV_SX;
            endcase
            state_q <= (src_q == DIV_EY) ? ST_CHECK : ST_DIV;
          end
        end
        ST_CHECK: begin
          if (sts_i.same_tile) begin
            oc_q    <= OC_SAME_TILE;
            state_q <= ST_EMIT;
          end else begin
            first_q <= 1'b1;
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: state_q <= ST_TEST;
        ST_TEST: begin
          if (sts_i.solid) begin
            if (first_q) begin
              oc_q    <= OC_START_SOLID;
              state_q <= ST_EMIT;
            end else begin
              state_q <= ST_HPREP;
            end
          end else begin
            state_q <= first_q ? ST_MX : ST_STEP;
          end
        end
        ST_MX: state_q <= ST_MY;
        ST_MY: state_q <= ST_IX;
        ST_IX: state_q <= ST_IY;
        ST_IY: state_q <= ST_STEP;
        ST_STEP: begin
          if (sts_i.same_tile) begin
            oc_q    <= OC_REACHED;
            state_q <= ST_EMIT;
          end else if (sts_i.step_limit) begin
            oc_q    <= OC_STEP_LIMIT;
            state_q <= ST_EMIT;
          end else begin
            first_q <= 1'b0;
            state_q <= ST_LOOK;
          end
        end
        ST_HPREP: state_q <= ST_HMUL;
        ST_HMUL:  state_q <= ST_HDIV;
        ST_HDIV:  state_q <= ST_HWAIT;
        ST_HWAIT: begin
          if (!sts_i.div_busy) begin
            oc_q    <= OC_HIT;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: if (sts_i.out_free) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free) else $error("result emitted over a pending one");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_go |-> !sts_i.div_busy) else $error("divider started while busy");
  a_step_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> !sts_i.same_tile && !sts_i.step_limit) else $error("step past walk end");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !sts_i.div_busy) else $error("item taken while dividing");
`endif

endmodule

/* hdl/tile_grid_ray_traversal_unit.sv */
// top level of the tile grid ray traversal unit
//
// casts rays through a layered tile map of up to MAX_MAP_COLS x MAX_MAP_ROWS tiles, one
// item at a time; a tile-write item (tuser 0) writes one tile of its layer, a cast
// (tuser 1) runs a setup (four floored tile divisions on the shared bit-serial
// divider, the same-tile check, the start tile test, then four multiplies), then per
// tile walked a step, ram read and solid test, and on a hit the 43-bit hit-point
// division; after reset
// a clearing pass zeroes the tile store, one cell of every layer per cycle, so no item
// is taken until all MAX_MAP_COLS*MAX_MAP_ROWS cells (16384 as built) are cleared; config
// writes are always taken and must only be issued while the unit is idle
module tile_grid_ray_traversal_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input item
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // layer_index, tile_x, tile_y, tile_value, start_x, start_y, end_x, end_y, zero pad
  input  logic [tgrt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // mode
  input  logic [0:0]                         s_axis_tuser,
  // result item
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // point_x, point_y, hit_col, hit_row, zero pad
  output logic [tgrt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // outcome
  output logic [tgrt_pkg::OC_W-1:0]          m_axis_tuser,
  // register writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tgrt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tgrt_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import tgrt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // register port never stalls
  assign cfg_ready_o = 1'b1;

  // sequencer: owns the item handshake and steps the datapath
  tgrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_mode_i   (s_axis_tuser[0]),
    .s_tready_o (s_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // datapath: tile store, divider, walk accumulators and the result register
  tgrt_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .s_tdata_i   (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_o   (m_axis_tdata),
    .m_tuser_o   (m_axis_tuser)
  );

endmodule
